@@ design/b2b_pkg.sv @@
// Shared constants and types for the B-spline to Bezier converter.
`default_nettype none

package b2b_pkg;

  // Digit width handled by one stage of the divide-by-three pipeline
  localparam int B2B_DIGIT = 16;
  // Reciprocal of three for one digit plus a two-bit remainder:
  // floor(v * B2B_RECIP3 / 2**B2B_RSHIFT) == floor(v / 3) for v < 2**B2B_RSHIFT
  localparam int B2B_RECIP_BITS = B2B_DIGIT + 2;
  localparam int B2B_RSHIFT = B2B_DIGIT + 3;
  localparam logic [B2B_RECIP_BITS-1:0] B2B_RECIP3 = 18'd174763;

  // Result position within the run caused by one de Boor point
  localparam logic [1:0] IDX_E   = 2'd0;
  localparam logic [1:0] IDX_F   = 2'd1;
  localparam logic [1:0] IDX_G   = 2'd2;
  localparam logic [1:0] IDX_END = 2'd3;

  // Role codes on the result channel
  localparam logic [1:0] ROLE_JUNCTION = 2'd0;
  localparam logic [1:0] ROLE_INNER1   = 2'd1;
  localparam logic [1:0] ROLE_INNER2   = 2'd2;

  // Point count at saturation, and the count at which the window is full
  localparam logic [2:0] PS_FULL = 3'd4;
  localparam logic [2:0] PS_READY = 3'd3;

  // Side-band tag that travels beside each result
  typedef struct packed {
    logic [1:0] role;
    logic       run_end;
    logic       curve_end;
  } tag_t;

endpackage

`default_nettype wire

@@ design/b2b_if.sv @@
// Point and Bezier result channel interfaces.
`default_nettype none

interface b2b_point_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  logic                         final_point;

  modport source (output valid, px, py, pz, final_point, input ready);
  modport sink (input valid, px, py, pz, final_point, output ready);
endinterface

interface b2b_bez_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] bz;
  logic [1:0]                   role;
  logic                         run_end;
  logic                         curve_end;

  modport source (output valid, bx, by, bz, role, run_end, curve_end, input ready);
  modport sink (input valid, bx, by, bz, role, run_end, curve_end, output ready);
endinterface

`default_nettype wire

@@ design/b2b_div3.sv @@
// Pipelined unsigned divide-by-three, one 16-bit digit per stage, top digit first.
`default_nettype none

module b2b_div3
  import b2b_pkg::*;
#(
  parameter int WIDTH = 37
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] quot
);

  localparam int NSTG = (WIDTH + B2B_DIGIT - 1) / B2B_DIGIT;
  localparam int PW   = NSTG * B2B_DIGIT;
  localparam int VW   = B2B_DIGIT + 2;
  localparam int MW   = VW + B2B_RECIP_BITS;

  // Dividend with the digits done so far replaced by quotient digits
  logic [PW-1:0] val [NSTG];
  logic [1:0]    rem [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int POS = (NSTG - 1 - s) * B2B_DIGIT;

    logic [PW-1:0]        vin;
    logic [1:0]           rin;
    logic [VW-1:0]        v;
    logic [MW-1:0]        prod;
    logic [B2B_DIGIT-1:0] qd;
    logic [VW-1:0]        rfull;
    logic [PW-1:0]        vout;

    if (s == 0) begin : g_head
      assign vin = PW'(din);
      assign rin = 2'd0;
    end else begin : g_body
      assign vin = val[s-1];
      assign rin = rem[s-1];
    end

    // Divide remainder and digit by multiplying with the reciprocal
    assign v     = {rin, vin[POS +: B2B_DIGIT]};
    assign prod  = MW'(v) * MW'(B2B_RECIP3);
    assign qd    = prod[B2B_RSHIFT +: B2B_DIGIT];
    assign rfull = v - (VW'({qd, 1'b0}) + VW'(qd));

    // Swap the current digit for its quotient digit
    always_comb begin
      vout                   = vin;
      vout[POS +: B2B_DIGIT] = qd;
    end

    // Advance one digit
    always_ff @(posedge clk) begin
      if (en) begin
        val[s] <= vout;
        rem[s] <= rfull[1:0];
      end
    end
  end

  assign quot = val[NSTG-1][WIDTH-1:0];

endmodule

`default_nettype wire

@@ design/bspline_to_bezier_converter.sv @@
// Uniform cubic B-spline to Bezier control point converter, top level.
//
// Usage: de Boor points enter on the pt channel (valid/ready, a transfer when
// both are high), with final_point set on the last point of a curve. Bezier
// control points leave on the bez channel, one per transfer. From the fourth
// point of a curve on, each point yields the junction point, then the two
// inner points; the last point also yields the curve end point with
// curve_end set. A curve of fewer than four points yields nothing.
// Throughput: each point that yields results holds the issue register until
// its last result issues, one result per cycle while bez.ready stays high;
// the next point is taken as that last result issues. Points that yield
// nothing are taken when the issue register is free.
// Path: after its point is taken, each result passes the issue stage register,
// the digit stages of the divide-by-three pipeline and the output register.
// Reset (rst, synchronous) empties the pipeline and starts a new curve.
// When the receiver stalls, the whole result pipeline holds and pt.ready
// drops once the issue register is full; nothing is lost.
`default_nettype none

module bspline_to_bezier_converter
  import b2b_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  b2b_point_if.sink  pt,
  b2b_bez_if.source  bez
);

  localparam int NW   = COORD_BITS + 4;
  localparam int UW   = NW + 1;
  localparam int NSTG = (UW + B2B_DIGIT - 1) / B2B_DIGIT;
  localparam logic [UW-1:0] BIAS = {2'b11, {(NW-1){1'b0}}};

  logic                  acc;
  logic                  adv;
  logic [COORD_BITS-1:0] pin [3];

  // Window of the three previous points, oldest first
  logic [COORD_BITS-1:0] win [3][3];
  logic [2:0]            points_seen;

  // Issue register: one point's operands and the result count
  logic                  job_valid;
  logic                  job_first;
  logic                  job_last;
  logic [1:0]            job_idx;
  logic [COORD_BITS-1:0] job_pt [3][4];
  logic                  issue;
  logic                  issue_last;

  logic [UW-1:0]         iss_u_next [3];
  tag_t                  iss_tag_next;
  logic                  iss_valid;
  logic [UW-1:0]         iss_u [3];
  tag_t                  iss_tag;

  logic [UW-1:0]         quot [3];
  logic                  tv [NSTG];
  tag_t                  tt [NSTG];

  logic                  out_valid;
  logic [COORD_BITS-1:0] out_b [3];
  tag_t                  out_tag;

  assign pin[0] = pt.px;
  assign pin[1] = pt.py;
  assign pin[2] = pt.pz;

  assign adv        = !out_valid || bez.ready;
  assign issue      = job_valid && adv;
  assign issue_last = (job_idx == (job_last ? IDX_END : IDX_G));
  assign pt.ready   = !job_valid || (adv && issue_last);
  assign acc        = pt.valid && pt.ready;

  // Track the window; drop it at the end of a curve
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
    end else if (acc) begin
      if (pt.final_point) begin
        points_seen <= '0;
      end else if (points_seen != PS_FULL) begin
        points_seen <= points_seen + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int a = 0; a < 3; a++) begin
        win[a][0] <= win[a][1];
        win[a][1] <= win[a][2];
        win[a][2] <= pin[a];
      end
    end
  end

  // Load the issue register and step through the results of one point
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= IDX_E;
      job_first <= 1'b0;
      job_last  <= 1'b0;
    end else begin
      if (issue) begin
        if (issue_last) begin
          job_valid <= 1'b0;
        end else begin
          job_idx <= job_idx + 2'd1;
        end
      end
      if (acc && points_seen >= PS_READY) begin
        job_valid <= 1'b1;
        job_idx   <= IDX_E;
        job_first <= (points_seen == PS_READY);
        job_last  <= pt.final_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && points_seen >= PS_READY) begin
      for (int a = 0; a < 3; a++) begin
        job_pt[a][0] <= win[a][0];
        job_pt[a][1] <= win[a][1];
        job_pt[a][2] <= win[a][2];
        job_pt[a][3] <= pin[a];
      end
    end
  end

  // Form the weighted numerator, take the power-of-two part of the divisor
  // with a floor shift and bias the value positive for the divide by three
  always_comb begin
    logic signed [NW-1:0] x0, x1, x2, num, sh;
    for (int a = 0; a < 3; a++) begin
      if (job_idx == IDX_END) begin
        x0 = {{4{job_pt[a][1][COORD_BITS-1]}}, job_pt[a][1]};
        x1 = {{4{job_pt[a][2][COORD_BITS-1]}}, job_pt[a][2]};
        x2 = {{4{job_pt[a][3][COORD_BITS-1]}}, job_pt[a][3]};
      end else begin
        x0 = {{4{job_pt[a][0][COORD_BITS-1]}}, job_pt[a][0]};
        x1 = {{4{job_pt[a][1][COORD_BITS-1]}}, job_pt[a][1]};
        x2 = {{4{job_pt[a][2][COORD_BITS-1]}}, job_pt[a][2]};
      end
      case (job_idx)
        IDX_E: begin
          if (job_first) begin
            num = (x0 <<< 1) + x0 + (x1 <<< 3) - x1 + (x2 <<< 1);
            sh  = num >>> 2;
          end else begin
            num = x0 + (x1 <<< 2) + x2;
            sh  = num >>> 1;
          end
        end
        IDX_F: begin
          num = (x1 <<< 1) + x2;
          sh  = num;
        end
        IDX_G: begin
          num = x1 + (x2 <<< 1);
          sh  = num;
        end
        default: begin
          num = (x0 <<< 1) + (x1 <<< 3) - x1 + (x2 <<< 1) + x2;
          sh  = num >>> 2;
        end
      endcase
      iss_u_next[a] = {sh[NW-1], sh} + BIAS;
    end
  end

  // Tag each result with its role and run markers
  always_comb begin
    iss_tag_next.curve_end = (job_idx == IDX_END);
    iss_tag_next.run_end   = (job_idx == IDX_END) || (job_idx == IDX_G && !job_last);
    case (job_idx)
      IDX_F:   iss_tag_next.role = ROLE_INNER1;
      IDX_G:   iss_tag_next.role = ROLE_INNER2;
      default: iss_tag_next.role = ROLE_JUNCTION;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else if (adv) begin
      iss_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      iss_u   <= iss_u_next;
      iss_tag <= iss_tag_next;
    end
  end

  // Divide by three, one lane per axis
  for (genvar a = 0; a < 3; a++) begin : g_div
    b2b_div3 #(
      .WIDTH (UW)
    ) u_div3 (
      .clk  (clk),
      .en   (adv),
      .din  (iss_u[a]),
      .quot (quot[a])
    );
  end

  // Carry valid and tag alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTG; s++) begin
        tv[s] <= 1'b0;
      end
    end else if (adv) begin
      tv[0] <= iss_valid;
      for (int s = 1; s < NSTG; s++) begin
        tv[s] <= tv[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tt[0] <= iss_tag;
      for (int s = 1; s < NSTG; s++) begin
        tt[s] <= tt[s-1];
      end
    end
  end

  // Output register; the bias only touches bits above the coordinate width
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tv[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        out_b[a] <= quot[a][COORD_BITS-1:0];
      end
      out_tag <= tt[NSTG-1];
    end
  end

  assign bez.valid     = out_valid;
  assign bez.bx        = out_b[0];
  assign bez.by        = out_b[1];
  assign bez.bz        = out_b[2];
  assign bez.role      = out_tag.role;
  assign bez.run_end   = out_tag.run_end;
  assign bez.curve_end = out_tag.curve_end;

  // The end point is only ever issued for the final point of a curve
  a_end_only_last: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_idx == IDX_END |-> job_last)
    else $error("end point issued for a point that is not final");

  a_points_sat: assert property (@(posedge clk) disable iff (rst)
    points_seen <= PS_FULL)
    else $error("point count beyond saturation");

  a_curve_end_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tag.curve_end |-> out_tag.run_end && out_tag.role == ROLE_JUNCTION)
    else $error("curve end result without run end or junction role");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    acc && pt.final_point |=> points_seen == 3'd0)
    else $error("window not cleared after final point");

endmodule

`default_nettype wire
